### rtl/fwagc_pkg.sv
package fwagc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH   = 2'd0,
        REG_REFERENCE_LEVEL = 2'd1,
        REG_ENVELOPE_FLOOR  = 2'd2
    } cfg_index_t;

    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;
    localparam int WL_WIDTH       = 7;
    localparam int LEVEL_WIDTH    = 16;

    localparam logic [WL_WIDTH-1:0]    WL_RESET    = 7'd16;
    localparam logic [LEVEL_WIDTH-1:0] REF_RESET   = 16'd16384;
    localparam logic [LEVEL_WIDTH-1:0] FLOOR_RESET = 16'd1;

    // Envelope weight of the smaller magnitude, 0.4 in Q0.15
    localparam int ENV_COEF_WIDTH = 14;
    localparam logic [ENV_COEF_WIDTH-1:0] ENV_COEF = 14'd13107;
    localparam int ENV_SHIFT = 15;

    typedef struct packed {
        logic [WL_WIDTH-1:0]    window_length;
        logic [LEVEL_WIDTH-1:0] reference_level;
        logic [LEVEL_WIDTH-1:0] envelope_floor;
    } agc_cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_DRAIN,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_HOLD
    } back_state_t;

endpackage

### rtl/fwagc_ifs.sv
interface fwagc_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_i;
    logic signed [SAMPLE_WIDTH-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fwagc_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;

    modport source (output valid, output out_i, output out_q, input ready);
    modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

### rtl/fwagc_front.sv
module fwagc_front #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int PEAK_WIDTH   = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fwagc_pkg::agc_cfg_t         cfg,
    fwagc_in_if.sink                    sample_in,
    output logic                        push_valid,
    input  logic                        push_ready,
    output logic [SAMPLE_WIDTH-1:0]     push_i,
    output logic [SAMPLE_WIDTH-1:0]     push_q,
    output logic [PEAK_WIDTH-1:0]       push_peak
);
    import fwagc_pkg::*;

    localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW  = $clog2(MAX_WINDOW + 1);
    localparam int EW  = SAMPLE_WIDTH + 1;
    localparam int PW  = SAMPLE_WIDTH + ENV_COEF_WIDTH;

    front_state_t state_reg, state_next;

    logic [AW-1:0]   wr_reg;
    logic [LW-1:0]   k_reg;
    logic [LW-1:0]   len;
    logic [MAX_WINDOW-1:0] vld_reg;

    logic [2*SAMPLE_WIDTH-1:0] smp_mem [MAX_WINDOW];
    logic [EW-1:0]             env_mem [MAX_WINDOW];

    logic [EW-1:0]             env_rd_reg;
    logic                      env_ok_reg;
    logic                      rd_live_reg;
    logic [2*SAMPLE_WIDTH-1:0] smp_rd_reg;
    logic                      smp_ok_reg;
    logic [PEAK_WIDTH-1:0]     peak_reg;

    logic [SAMPLE_WIDTH-1:0] mag_i, mag_q, hi, lo;
    logic [PW-1:0]           lo_prod;
    logic [EW-1:0]           env_new;
    logic [AW-1:0]           env_addr, old_addr;
    logic [PEAK_WIDTH-1:0]   floor1;
    logic                    accept;

    // Step back from the write position, modulo the store depth
    function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] pos,
                                                input logic [LW-1:0] off);
        logic [AW+1:0] t;
        t = (AW+2)'(pos) + (AW+2)'(MAX_WINDOW) - (AW+2)'(off);
        if (t >= (AW+2)'(MAX_WINDOW))
            t = t - (AW+2)'(MAX_WINDOW);
        return t[AW-1:0];
    endfunction

    // Clamp the window length to the range one to the store depth
    always_comb
    begin
        if (cfg.window_length == '0)
            len = LW'(1);
        else if (int'(cfg.window_length) > MAX_WINDOW)
            len = LW'(MAX_WINDOW);
        else
            len = LW'(cfg.window_length);
    end

    assign floor1 = (cfg.envelope_floor == '0) ? PEAK_WIDTH'(1)
                                               : PEAK_WIDTH'(cfg.envelope_floor);

    // Envelope: max plus 0.4 times min of the magnitudes
    always_comb
    begin
        mag_i   = sample_in.sample_i[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample_in.sample_i)
                                                     : SAMPLE_WIDTH'(sample_in.sample_i);
        mag_q   = sample_in.sample_q[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-sample_in.sample_q)
                                                     : SAMPLE_WIDTH'(sample_in.sample_q);
        hi      = (mag_i > mag_q) ? mag_i : mag_q;
        lo      = (mag_i > mag_q) ? mag_q : mag_i;
        lo_prod = PW'(lo) * PW'(ENV_COEF);
        env_new = EW'(hi) + EW'(lo_prod >> ENV_SHIFT);
    end

    assign sample_in.ready = (state_reg == F_IDLE);
    assign accept          = sample_in.valid && sample_in.ready;
    assign env_addr        = wrap_back(wr_reg, k_reg);
    assign old_addr        = wrap_back(wr_reg, len - LW'(1));

    // Store the new sample and read the window back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_mem[wr_reg] <= {sample_in.sample_i, sample_in.sample_q};
            env_mem[wr_reg] <= env_new;
        end
        env_rd_reg <= env_mem[env_addr];
        smp_rd_reg <= smp_mem[old_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_SCAN;
            F_SCAN:  if (k_reg == len - LW'(1)) state_next = F_DRAIN;
            F_DRAIN: state_next = F_PUSH;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Scan counter, write pointer, valid bits, running peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg      <= '0;
            k_reg       <= '0;
            vld_reg     <= '0;
            rd_live_reg <= 1'b0;
            env_ok_reg  <= 1'b0;
            smp_ok_reg  <= 1'b0;
            peak_reg    <= '0;
        end
        else
        begin
            rd_live_reg <= (state_reg == F_SCAN);
            env_ok_reg  <= vld_reg[env_addr];
            if (state_reg == F_SCAN && k_reg == '0)
                smp_ok_reg <= vld_reg[old_addr];
            if (accept)
            begin
                vld_reg[wr_reg] <= 1'b1;
                k_reg           <= '0;
                peak_reg        <= floor1;
            end
            else if (state_reg == F_SCAN)
                k_reg <= k_reg + LW'(1);
            if (rd_live_reg && env_ok_reg && PEAK_WIDTH'(env_rd_reg) > peak_reg)
                peak_reg <= PEAK_WIDTH'(env_rd_reg);
            if (state_reg == F_PUSH && push_ready)
                wr_reg <= (int'(wr_reg) == MAX_WINDOW - 1) ? '0 : wr_reg + AW'(1);
        end
    end

    assign push_valid = (state_reg == F_PUSH);
    assign push_i     = smp_ok_reg ? smp_rd_reg[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] : '0;
    assign push_q     = smp_ok_reg ? smp_rd_reg[SAMPLE_WIDTH-1:0] : '0;
    assign push_peak  = peak_reg;

endmodule

### rtl/fwagc_queue.sv
module fwagc_queue #(
    parameter int WIDTH = 49
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    // Two-entry queue
    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

### rtl/fwagc_back.sv
module fwagc_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PEAK_WIDTH   = 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fwagc_pkg::LEVEL_WIDTH-1:0] reference_level,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  logic [SAMPLE_WIDTH-1:0]     pop_i,
    input  logic [SAMPLE_WIDTH-1:0]     pop_q,
    input  logic [PEAK_WIDTH-1:0]       pop_peak,
    fwagc_out_if.source                 result_out
);
    import fwagc_pkg::*;

    localparam int NW = SAMPLE_WIDTH + LEVEL_WIDTH;
    localparam int CW = $clog2(NW + 1);
    localparam int RW = PEAK_WIDTH + 1;
    localparam logic [NW-1:0] MAXP = NW'((1 << (SAMPLE_WIDTH - 1)) - 1);

    back_state_t state_reg, state_next;

    logic [SAMPLE_WIDTH-1:0] part_i_reg, part_q_reg;
    logic [PEAK_WIDTH-1:0]   div_reg;
    logic                    neg_i_reg, neg_q_reg;
    logic [NW-1:0]           num_i_reg, num_q_reg;
    logic [RW-1:0]           rem_i_reg, rem_q_reg;
    logic [CW-1:0]           cnt_reg;
    logic [SAMPLE_WIDTH-1:0] out_i_reg, out_q_reg;
    logic                    out_vld_reg;

    logic [SAMPLE_WIDTH-1:0] mag_i, mag_q;
    logic [RW-1:0]           sh_i, sh_q;
    logic                    ge_i, ge_q;
    logic                    load_out;

    // Saturate a quotient magnitude with its sign
    function automatic logic [SAMPLE_WIDTH-1:0] sat(input logic [NW-1:0] q,
                                                    input logic neg);
        logic [SAMPLE_WIDTH-1:0] r;
        if (neg)
            r = (q > MAXP + NW'(1)) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                    : SAMPLE_WIDTH'(-q);
        else
            r = (q > MAXP) ? MAXP[SAMPLE_WIDTH-1:0] : q[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    assign mag_i = part_i_reg[SAMPLE_WIDTH-1] ? -part_i_reg : part_i_reg;
    assign mag_q = part_q_reg[SAMPLE_WIDTH-1] ? -part_q_reg : part_q_reg;

    // One restoring division step for both parts
    always_comb
    begin
        sh_i = {rem_i_reg[RW-2:0], num_i_reg[NW-1]};
        sh_q = {rem_q_reg[RW-2:0], num_q_reg[NW-1]};
        ge_i = (sh_i >= RW'(div_reg));
        ge_q = (sh_q >= RW'(div_reg));
    end

    assign pop_ready = (state_reg == B_IDLE);
    assign load_out  = (state_reg == B_HOLD) && (!out_vld_reg || result_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (pop_valid) state_next = B_MUL;
            B_MUL:   state_next = B_DIV;
            B_DIV:   if (cnt_reg == CW'(NW - 1)) state_next = B_HOLD;
            B_HOLD:  if (load_out) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath: load, multiply, shift-subtract, saturate into the output register
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                part_i_reg <= pop_i;
                part_q_reg <= pop_q;
                div_reg    <= pop_peak;
            end
            B_MUL:
            begin
                num_i_reg <= NW'(mag_i) * NW'(reference_level);
                num_q_reg <= NW'(mag_q) * NW'(reference_level);
                neg_i_reg <= part_i_reg[SAMPLE_WIDTH-1];
                neg_q_reg <= part_q_reg[SAMPLE_WIDTH-1];
                rem_i_reg <= '0;
                rem_q_reg <= '0;
                cnt_reg   <= '0;
            end
            B_DIV:
            begin
                rem_i_reg <= ge_i ? sh_i - RW'(div_reg) : sh_i;
                rem_q_reg <= ge_q ? sh_q - RW'(div_reg) : sh_q;
                num_i_reg <= {num_i_reg[NW-2:0], ge_i};
                num_q_reg <= {num_q_reg[NW-2:0], ge_q};
                cnt_reg   <= cnt_reg + CW'(1);
            end
            B_HOLD:
            begin
                if (load_out)
                begin
                    out_i_reg <= sat(num_i_reg, neg_i_reg);
                    out_q_reg <= sat(num_q_reg, neg_q_reg);
                end
            end
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (load_out)
            out_vld_reg <= 1'b1;
        else if (result_out.ready)
            out_vld_reg <= 1'b0;
    end

    assign result_out.valid = out_vld_reg;
    assign result_out.out_i = out_i_reg;
    assign result_out.out_q = out_q_reg;

endmodule

### rtl/feedforward_window_agc.sv
// Feedforward AGC over a sliding window of complex samples. Each accepted sample is
// stored with its envelope, max(|I|,|Q|) + 0.4*min(|I|,|Q|); the block then scans the
// newest window_length envelopes one per cycle (single read port of the envelope store),
// takes the peak (at least envelope_floor) and emits the sample written window_length-1
// items earlier times reference_level / peak, truncated and saturated. The front takes
// a new item only once it has pushed the last one to the queue; the back's bit-serial
// divider takes one only once the last result is loaded into its output register, and
// a two-entry queue lets the two overlap. The delay store reads as zero until written
// after reset, with no clearing pass.
module feedforward_window_agc #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fwagc_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
    input  logic [fwagc_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    fwagc_in_if.sink                             sample_in,
    fwagc_out_if.source                          result_out
);
    import fwagc_pkg::*;

    localparam int PEAK_WIDTH = (SAMPLE_WIDTH + 1 > LEVEL_WIDTH) ? SAMPLE_WIDTH + 1
                                                                 : LEVEL_WIDTH;
    localparam int QW = 2 * SAMPLE_WIDTH + PEAK_WIDTH;

    agc_cfg_t cfg_reg;

    logic                    f_valid, f_ready, b_valid, b_ready;
    logic [SAMPLE_WIDTH-1:0] f_i, f_q;
    logic [PEAK_WIDTH-1:0]   f_peak;
    logic [QW-1:0]           b_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length   <= WL_RESET;
            cfg_reg.reference_level <= REF_RESET;
            cfg_reg.envelope_floor  <= FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WINDOW_LENGTH:   cfg_reg.window_length   <= cfg_data[WL_WIDTH-1:0];
                REG_REFERENCE_LEVEL: cfg_reg.reference_level <= cfg_data;
                REG_ENVELOPE_FLOOR:  cfg_reg.envelope_floor  <= cfg_data;
                default: ;
            endcase
        end
    end

    fwagc_front #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PEAK_WIDTH   (PEAK_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample_in  (sample_in),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_i     (f_i),
        .push_q     (f_q),
        .push_peak  (f_peak)
    );

    fwagc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_i, f_q, f_peak}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    fwagc_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PEAK_WIDTH   (PEAK_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .reference_level (cfg_reg.reference_level),
        .pop_valid       (b_valid),
        .pop_ready       (b_ready),
        .pop_i           (b_data[QW-1 -: SAMPLE_WIDTH]),
        .pop_q           (b_data[PEAK_WIDTH +: SAMPLE_WIDTH]),
        .pop_peak        (b_data[PEAK_WIDTH-1:0]),
        .result_out      (result_out)
    );

endmodule
